### rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants and state encodings of the LZSS decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int WinBitsDef      = 13;
  localparam int MinMatchDef     = 3;
  localparam int HistoryDepthDef = 16384;
  localparam int LanesDef        = 8;

  // Escape codes of the match length and the bases they commit.
  localparam logic [7:0] Esc2     = 8'd3;
  localparam logic [7:0] Esc3     = 8'd7;
  localparam logic [7:0] Esc5     = 8'd31;
  localparam logic [7:0] Esc8     = 8'd255;
  localparam logic [5:0] Base3    = 6'd3;
  localparam logic [5:0] Base5    = 6'd10;
  localparam logic [5:0] Base8    = 6'd41;
  localparam logic [8:0] FirstRun = 9'd296;
  localparam logic [8:0] NextRun  = 9'd255;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_BIT   = 10'b00_0000_0100,
    S_NEXT  = 10'b00_0000_1000,
    S_MOD   = 10'b00_0001_0000,
    S_SRC   = 10'b00_0010_0000,
    S_RD    = 10'b00_0100_0000,
    S_WR    = 10'b00_1000_0000,
    S_FLUSH = 10'b01_0000_0000,
    S_PUSH  = 10'b10_0000_0000
  } state_e;

  typedef enum logic [7:0] {
    P_FLAG = 8'b0000_0001,
    P_LIT  = 8'b0000_0010,
    P_OFS  = 8'b0000_0100,
    P_L2   = 8'b0000_1000,
    P_L3   = 8'b0001_0000,
    P_L5   = 8'b0010_0000,
    P_L8A  = 8'b0100_0000,
    P_L8B  = 8'b1000_0000
  } parse_e;

endpackage

### rtl/lzd_history_ram.sv
// ----------------------------------------------------------------------------
// LZSS history memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lzd_history_ram import lzd_pkg::*; #(
  parameter int Depth = HistoryDepthDef,
  parameter int Aw    = $clog2(HistoryDepthDef)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/lzss_decompressor.sv
// ----------------------------------------------------------------------------
// LZSS decompressor
// Bit-serial token parser with a history ring and byte-wise match copy.
// ----------------------------------------------------------------------------
// After reset the block sweeps the history memory to zero, one entry a cycle,
// and takes no beat meanwhile. A header beat is taken in S_IDLE. A data beat
// is accepted in S_IDLE, shifted out one bit per S_BIT step and closed in
// S_FLUSH. Each literal and each escape of the two-, three- or five-bit
// length field passes through S_NEXT. An offset passes through S_MOD, which
// takes HISTORY_DEPTH off a distance beyond the ring once per visit, and
// S_NEXT. A match copy passes through S_SRC, then S_RD and S_WR per copied
// byte, then S_NEXT. S_RD is the registered read of the history memory and
// S_WR writes the copied byte, so an overlapping copy sees the byte just
// written. Each group of decoded bytes is handed to the output register in
// S_PUSH, which waits while the output stalls. Once the decoded count
// reaches the header size, later beats are taken and dropped.
module lzss_decompressor import lzd_pkg::*; #(
  parameter int WIN_BITS      = WinBitsDef,
  parameter int MIN_MATCH     = MinMatchDef,
  parameter int HISTORY_DEPTH = HistoryDepthDef,
  parameter int LANES         = LanesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] lane0_o,
  output logic [7:0] lane1_o,
  output logic [7:0] lane2_o,
  output logic [7:0] lane3_o,
  output logic [7:0] lane4_o,
  output logic [7:0] lane5_o,
  output logic [7:0] lane6_o,
  output logic [7:0] lane7_o,
  output logic [3:0] byte_count_o,
  output logic       stream_done_o
);

  localparam int Aw   = $clog2(HISTORY_DEPTH);
  localparam int Dw   = WIN_BITS + 1;
  localparam int AccW = (WIN_BITS > 8) ? WIN_BITS : 8;
  localparam int Tw   = 17;

  state_e         state_q, state_d, ret_q, ret_d;
  parse_e         stage_q, stage_d;
  logic [2:0]     hdr_q, hdr_d;
  logic [31:0]    target_q, target_d;
  logic [31:0]    prod_q, prod_d;
  logic           finished_q, finished_d;
  logic [3:0]     left_q, left_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] acc_n;
  logic [Dw-1:0]  dist_q, dist_d;
  logic [5:0]     pend_q, pend_d;
  logic [8:0]     len_q, len_d;
  logic [7:0]     sh_q, sh_d;
  logic [3:0]     cnt_q, cnt_d;
  logic [Aw-1:0]  pos_q, pos_d, src_q, src_d, clr_q, clr_d;
  logic [7:0]     grp_q [8];
  logic [7:0]     grp_d [8];
  logic [3:0]     grp_n_q, grp_n_d;
  logic           done_q, done_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_lane_q [8];
  logic [7:0]     out_lane_d [8];
  logic [3:0]     out_cnt_q, out_cnt_d;
  logic           out_done_q, out_done_d;

  logic           put;
  logic [7:0]     pbyte;
  logic           bit_v;
  logic [3:0]     left_n;
  logic [Tw-1:0]  tmp;
  logic           ram_we;
  logic [Aw-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;

  lzd_history_ram #(
    .Depth(HISTORY_DEPTH),
    .Aw   (Aw)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(src_q),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign bit_v      = sh_q[7];
  assign acc_n      = {acc_q[AccW-2:0], bit_v};
  assign left_n     = left_q - 4'd1;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    stage_d     = stage_q;
    hdr_d       = hdr_q;
    target_d    = target_q;
    prod_d      = prod_q;
    finished_d  = finished_q;
    left_d      = left_q;
    acc_d       = acc_q;
    dist_d      = dist_q;
    pend_d      = pend_q;
    len_d       = len_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    src_d       = src_q;
    clr_d       = clr_q;
    grp_d       = grp_q;
    grp_n_d     = grp_n_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    out_lane_d  = out_lane_q;
    out_cnt_d   = out_cnt_q;
    out_done_d  = out_done_q;
    put         = 1'b0;
    pbyte       = ram_rdata;
    tmp         = '0;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = 8'd0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + Aw'(1);
        if (clr_q == Aw'(HISTORY_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && !finished_q) begin
          if (hdr_q != 3'd4) begin
            target_d = {target_q[23:0], in_byte_i};
            hdr_d    = hdr_q + 3'd1;
            if (hdr_q == 3'd3 && target_d == 32'd0) begin
              finished_d = 1'b1;
            end
          end else begin
            sh_d    = in_byte_i;
            cnt_d   = 4'd8;
            state_d = S_BIT;
          end
        end
      end
      S_BIT: begin
        sh_d    = {sh_q[6:0], 1'b0};
        cnt_d   = cnt_q - 4'd1;
        state_d = (cnt_q == 4'd1) ? S_FLUSH : S_BIT;
        if (stage_q == P_FLAG) begin
          stage_d = bit_v ? P_OFS : P_LIT;
          left_d  = bit_v ? 4'(WIN_BITS) : 4'd8;
          acc_d   = '0;
        end else if (left_n != 4'd0) begin
          acc_d  = acc_n;
          left_d = left_n;
        end else begin
          acc_d  = '0;
          left_d = 4'd0;
          stage_d = P_FLAG;
          unique case (stage_q)
            P_LIT: begin
              put     = 1'b1;
              pbyte   = acc_n[7:0];
              state_d = S_NEXT;
            end
            P_OFS: begin
              dist_d  = Dw'(acc_n) + Dw'(MIN_MATCH);
              pend_d  = 6'd0;
              stage_d = P_L2;
              left_d  = 4'd2;
              state_d = S_MOD;
            end
            P_L2, P_L3, P_L5, P_L8A, P_L8B: begin
              state_d = S_SRC;
              len_d   = 9'(pend_q) + 9'(acc_n[7:0]) + 9'(MIN_MATCH);
              pend_d  = 6'd0;
              if (stage_q == P_L2 && acc_n[1:0] == Esc2[1:0]) begin
                pend_d  = Base3;
                stage_d = P_L3;
                left_d  = 4'd3;
                state_d = S_NEXT;
              end else if (stage_q == P_L3 && acc_n[2:0] == Esc3[2:0]) begin
                pend_d  = Base5;
                stage_d = P_L5;
                left_d  = 4'd5;
                state_d = S_NEXT;
              end else if (stage_q == P_L5 && acc_n[4:0] == Esc5[4:0]) begin
                pend_d  = Base8;
                stage_d = P_L8A;
                left_d  = 4'd8;
                state_d = S_NEXT;
              end else if (stage_q == P_L8A && acc_n[7:0] == Esc8) begin
                len_d   = FirstRun;
                stage_d = P_L8B;
                left_d  = 4'd8;
              end else if (stage_q == P_L8B && acc_n[7:0] == Esc8) begin
                len_d   = NextRun;
                stage_d = P_L8B;
                left_d  = 4'd8;
              end
            end
            default: begin
              stage_d = P_FLAG;
              state_d = S_NEXT;
            end
          endcase
        end
      end
      S_NEXT: begin
        state_d = (cnt_q == 4'd0) ? S_FLUSH : S_BIT;
      end
      S_MOD: begin
        if (Tw'(dist_q) >= Tw'(HISTORY_DEPTH)) begin
          dist_d = Dw'(Tw'(dist_q) - Tw'(HISTORY_DEPTH));
        end else begin
          state_d = S_NEXT;
        end
      end
      S_SRC: begin
        tmp = Tw'(pos_q) + Tw'(HISTORY_DEPTH) - Tw'(dist_q);
        if (tmp >= Tw'(HISTORY_DEPTH)) begin
          tmp = tmp - Tw'(HISTORY_DEPTH);
        end
        src_d   = Aw'(tmp);
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        put     = 1'b1;
        pbyte   = ram_rdata;
        src_d   = (src_q == Aw'(HISTORY_DEPTH - 1)) ? '0 : src_q + Aw'(1);
        len_d   = len_q - 9'd1;
        state_d = (len_q == 9'd1) ? S_NEXT : S_RD;
      end
      S_FLUSH: begin
        ret_d   = S_IDLE;
        state_d = (grp_n_q == 4'd0) ? S_IDLE : S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_cnt_d   = grp_n_q;
          out_done_d  = done_q;
          for (int k = 0; k < 8; k++) begin
            out_lane_d[k] = (4'(k) < grp_n_q) ? grp_q[k] : 8'd0;
          end
          grp_n_d = 4'd0;
          done_d  = 1'b0;
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (put) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q;
      ram_wdata = pbyte;
      pos_d     = (pos_q == Aw'(HISTORY_DEPTH - 1)) ? '0 : pos_q + Aw'(1);
      prod_d    = prod_q + 32'd1;
      grp_d[grp_n_q[2:0]] = pbyte;
      grp_n_d   = grp_n_q + 4'd1;
      if (prod_d == target_q) begin
        finished_d = 1'b1;
        done_d     = 1'b1;
        ret_d      = S_IDLE;
        state_d    = S_PUSH;
      end else if (grp_n_d == 4'(LANES)) begin
        ret_d   = state_d;
        state_d = S_PUSH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      stage_q     <= P_FLAG;
      hdr_q       <= 3'd0;
      target_q    <= 32'd0;
      prod_q      <= 32'd0;
      finished_q  <= 1'b0;
      left_q      <= 4'd0;
      acc_q       <= '0;
      dist_q      <= '0;
      pend_q      <= 6'd0;
      len_q       <= 9'd0;
      cnt_q       <= 4'd0;
      pos_q       <= '0;
      src_q       <= '0;
      clr_q       <= '0;
      grp_n_q     <= 4'd0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      stage_q     <= stage_d;
      hdr_q       <= hdr_d;
      target_q    <= target_d;
      prod_q      <= prod_d;
      finished_q  <= finished_d;
      left_q      <= left_d;
      acc_q       <= acc_d;
      dist_q      <= dist_d;
      pend_q      <= pend_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      src_q       <= src_d;
      clr_q       <= clr_d;
      grp_n_q     <= grp_n_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    grp_q      <= grp_d;
    out_lane_q <= out_lane_d;
    out_cnt_q  <= out_cnt_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign lane0_o       = out_lane_q[0];
  assign lane1_o       = out_lane_q[1];
  assign lane2_o       = out_lane_q[2];
  assign lane3_o       = out_lane_q[3];
  assign lane4_o       = out_lane_q[4];
  assign lane5_o       = out_lane_q[5];
  assign lane6_o       = out_lane_q[6];
  assign lane7_o       = out_lane_q[7];
  assign byte_count_o  = out_cnt_q;
  assign stream_done_o = out_done_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o != 4'd0) && (byte_count_o <= 4'(LANES)))
    else $error("Beat with an impossible byte count.");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (grp_n_q != 4'd0))
    else $error("Empty group handed to the output register.");

  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("Finished flag dropped.");

  a_done_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> finished_q)
    else $error("Last beat marked before the stream ended.");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_n_q <= 4'(LANES))
    else $error("Group grew beyond the lane count.");

endmodule
